// ----- hdl/qecs_pkg.sv -----
// ----------------------------------------------------------------------------
// qecs_pkg
// Shared types and constants of the quadrature edge counter and speed unit.
// ----------------------------------------------------------------------------
package qecs_pkg;

    // fixed field widths
    localparam int TIME_IN_W  = 32;
    localparam int POS_W      = 32;
    localparam int SPEED_W    = 25;
    localparam int SCALE_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register map, selected by paddr[2]
    localparam logic REG_SENSE = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd3582464;

    // speed saturation limits
    localparam logic [SCALE_W-1:0] SPEED_POS_MAX = 32'd16777215;
    localparam logic [SCALE_W-1:0] SPEED_NEG_MAX = 32'd16777216;

    // configuration seen by the datapath
    typedef struct packed {
        logic               count_sense;
        logic [SCALE_W-1:0] speed_scale;
    } t_cfg;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hdl/qecs_if.sv -----
// ----------------------------------------------------------------------------
// qecs channel interfaces
// Valid/ready channels for encoder samples and measurement results.
// ----------------------------------------------------------------------------
interface qecs_in_if
    import qecs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 edge_seen;
    logic                 phase_a;
    logic                 phase_b;
    logic [TIME_IN_W-1:0] time_us;

    modport source (output valid, output edge_seen, output phase_a, output phase_b,
                    output time_us, input ready);
    modport sink   (input valid, input edge_seen, input phase_a, input phase_b,
                    input time_us, output ready);
endinterface

interface qecs_out_if
    import qecs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   position_count;
    logic signed [SPEED_W-1:0] speed_q8;
    logic                      just_reversed;
    logic                      moving_backward;

    modport source (output valid, output position_count, output speed_q8,
                    output just_reversed, output moving_backward, input ready);
    modport sink   (input valid, input position_count, input speed_q8,
                    input just_reversed, input moving_backward, output ready);
endinterface

// ----- hdl/qecs_regs.sv -----
// ----------------------------------------------------------------------------
// qecs_regs
// APB register file: count sense and speed scale.
// ----------------------------------------------------------------------------
module qecs_regs
    import qecs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic               r_sense;
    logic [SCALE_W-1:0] r_scale;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense <= 1'b0;
            r_scale <= SCALE_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SENSE: r_sense <= pwdata[0];
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                default:   r_sense <= r_sense;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_SENSE: prdata = {{(APB_DATA_W-1){1'b0}}, r_sense};
            REG_SCALE: prdata = r_scale;
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.count_sense = r_sense;
    assign o_cfg.speed_scale = r_scale;

endmodule

// ----- hdl/qecs_div.sv -----
// ----------------------------------------------------------------------------
// qecs_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qecs_div
    import qecs_pkg::*;
#(
    parameter int QW = 32,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [QW-1:0] o_quotient,
    output t_div_stat     o_stat
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvsr;
    logic [QW-1:0]    r_quo;
    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;
    logic [VW-1:0]    n_rem;

    // one trial subtraction per step
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvsr};
    assign w_ge    = w_trial >= {1'b0, r_dvsr};
    assign n_rem   = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvsr <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

// ----- hdl/quadrature_edge_counter_speed_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_edge_counter_speed_unit
// One encoder channel: x2 edge counting on phase A and period-based speed.
// ----------------------------------------------------------------------------
// On acceptance the sample time is registered and, for an edge, the count
// and edge times are updated. The load state then forms the period and
// starts the restoring divider. The divider takes 32 steps, one quotient bit
// a cycle, to form speed_scale over the period. The divide state sees the
// divider finish, and the finish state saturates, signs and registers the
// speed once the output register is free. After a direction reversal the
// divider is skipped and the load state goes straight to the finish state.
// A new sample is accepted only once the result is registered and the
// sequencer is back in idle. A finished result waits in the output register,
// so the next sample can be accepted while it is still pending.
module quadrature_edge_counter_speed_unit
    import qecs_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qecs_in_if.sink               i_in_ch,
    qecs_out_if.source            o_out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    t_cfg                   w_cfg;
    t_div_stat              w_div_stat;
    logic [SCALE_W-1:0]     w_quo;

    logic [1:0]             r_state;
    logic [COUNT_BITS-1:0]  r_edge_count;
    logic                   r_dir_neg;
    logic                   r_dir_rev;
    logic [TIME_BITS-1:0]   r_last;
    logic [TIME_BITS-1:0]   r_prior;
    logic [TIME_BITS-1:0]   r_now;

    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_pos;
    logic [SPEED_W-1:0]     r_out_speed;
    logic                   r_out_rev;
    logic                   r_out_back;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_up;
    logic [63:0]            w_time_ext;
    logic [63:0]            w_cnt_ext;
    logic [TIME_BITS-1:0]   w_interval;
    logic [TIME_BITS-1:0]   w_since;
    logic [TIME_BITS-1:0]   w_period_raw;
    logic [TIME_BITS-1:0]   w_period;
    logic                   w_div_start;
    logic [SCALE_W-1:0]     w_mag;
    logic [SPEED_W-1:0]     w_speed;

    qecs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qecs_div #(
        .QW (SCALE_W),
        .VW (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cfg.speed_scale),
        .i_divisor  (w_period),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // handshakes
    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign w_in_xfer     = i_in_ch.valid & i_in_ch.ready;
    assign w_out_free    = !r_out_valid || o_out_ch.ready;

    // sample decode
    assign w_time_ext = 64'(i_in_ch.time_us);
    assign w_up       = ((i_in_ch.phase_a ^ i_in_ch.phase_b) == w_cfg.count_sense);

    // period: larger of last interval and time since last edge, at least one
    assign w_interval   = r_last - r_prior;
    assign w_since      = r_now - r_last;
    assign w_period_raw = (w_interval > w_since) ? w_interval : w_since;
    assign w_period     = (w_period_raw == '0) ? TIME_BITS'(1) : w_period_raw;
    assign w_div_start  = (r_state == ST_LOAD) && !r_dir_rev;

    // saturate and sign the quotient, or give zero speed after a reversal
    always_comb begin
        if (r_dir_rev) begin
            w_mag   = '0;
            w_speed = '0;
        end else if (!r_dir_neg) begin
            w_mag   = (w_quo > SPEED_POS_MAX) ? SPEED_POS_MAX : w_quo;
            w_speed = w_mag[SPEED_W-1:0];
        end else begin
            w_mag   = (w_quo > SPEED_NEG_MAX) ? SPEED_NEG_MAX : w_quo;
            w_speed = SPEED_W'(0) - w_mag[SPEED_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (w_in_xfer) r_state <= ST_LOAD;
                ST_LOAD: r_state <= r_dir_rev ? ST_FIN : ST_DIV;
                ST_DIV:  if (w_div_stat.done) r_state <= ST_FIN;
                ST_FIN:  if (w_out_free) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // edge count, direction and edge times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_dir_neg    <= 1'b0;
            r_dir_rev    <= 1'b0;
            r_last       <= '0;
            r_prior      <= '0;
        end else if (w_in_xfer && i_in_ch.edge_seen) begin
            r_prior <= r_last;
            r_last  <= w_time_ext[TIME_BITS-1:0];
            if (w_up) begin
                r_edge_count <= r_edge_count + 1'b1;
                r_dir_rev    <= r_dir_neg;
                r_dir_neg    <= 1'b0;
            end else begin
                r_edge_count <= r_edge_count - 1'b1;
                r_dir_rev    <= !r_dir_neg;
                r_dir_neg    <= 1'b1;
            end
        end
    end

    // sample time
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_now <= w_time_ext[TIME_BITS-1:0];
        end
    end

    // output register
    assign w_cnt_ext = 64'(r_edge_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_pos   <= w_cnt_ext[POS_W-1:0];
            r_out_speed <= w_speed;
            r_out_rev   <= r_dir_rev;
            r_out_back  <= r_dir_neg;
        end
    end

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.position_count  = r_out_pos;
    assign o_out_ch.speed_q8        = r_out_speed;
    assign o_out_ch.just_reversed   = r_out_rev;
    assign o_out_ch.moving_backward = r_out_back;

`ifndef SYNTHESIS
    // no new sample while the divider is still iterating
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.ready |-> !w_div_stat.busy)
        else $error("sample accepted with divider busy");

    // a reversal always reports zero speed
    a_rev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rev) |-> (r_out_speed == '0))
        else $error("nonzero speed after reversal");

    // an accepted sample moves straight to the period stage
    a_xfer_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_LOAD))
        else $error("sequencer missed accepted sample");
`endif

endmodule
